>>> src/prd_pkg.sv
// ----------------------------------------------------------------------------
// Primary ray direction package
// Shared widths, payload structs, configuration layout and stage bundles.
// ----------------------------------------------------------------------------
package prd_pkg;

	localparam int unsigned MAX_IMAGE_SIZE_DEF = 4096;
	localparam int unsigned DIR_FRAC_BITS_DEF  = 14;

	localparam int unsigned ROW_W   = 12;
	localparam int unsigned IDX_W   = 17;
	localparam int unsigned COMP_W  = 16;
	localparam int unsigned VEC_W   = 48;
	localparam int unsigned DIST_W  = 31;
	localparam int unsigned EDGE_W  = 32;
	localparam int unsigned PIXP_W  = 44;
	localparam int unsigned H_W     = 46;
	localparam int unsigned PROD_W  = 63;
	localparam int unsigned MAG_W   = 30;
	localparam int unsigned SQ_W    = 60;
	localparam int unsigned SUM_W   = 62;
	localparam int unsigned ROOT_W  = 31;
	localparam int unsigned TEST_W  = 64;
	localparam int unsigned OUT_W   = 16;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [31:0] OUT_POS_MAX = 32'd32767;
	localparam logic [31:0] OUT_NEG_MAX = 32'd32768;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAZE,
		REG_UP,
		REG_RIGHT,
		REG_NEAR_DIST,
		REG_NEAR_LEFT,
		REG_NEAR_TOP,
		REG_PIX_W,
		REG_PIX_H
	} cfg_reg_t;

	typedef struct packed {
		logic [ROW_W-1:0] pixel_row;
		logic [ROW_W-1:0] pixel_column;
	} pixel_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] dir_x;
		logic signed [OUT_W-1:0] dir_y;
		logic signed [OUT_W-1:0] dir_z;
	} dir_t;

	typedef struct packed {
		logic [VEC_W-1:0]         gaze;
		logic [VEC_W-1:0]         up;
		logic [VEC_W-1:0]         right;
		logic [DIST_W-1:0]        near_dist;
		logic signed [EDGE_W-1:0] near_left;
		logic signed [EDGE_W-1:0] near_top;
		logic [DIST_W-1:0]        pix_w;
		logic [DIST_W-1:0]        pix_h;
	} cam_cfg_t;

	typedef struct packed {
		logic signed [H_W-1:0] h;
		logic signed [H_W-1:0] v;
	} off_t;

	typedef struct packed {
		logic [2:0]             neg;
		logic [2:0][PROD_W-1:0] mag;
	} proj_t;

	typedef struct packed {
		logic                  zero;
		logic [2:0]            neg;
		logic [2:0][MAG_W-1:0] mag;
	} nrm_t;

	typedef struct packed {
		nrm_t             n;
		logic [SUM_W-1:0] sum;
	} nsum_t;

	typedef struct packed {
		nrm_t              n;
		logic [ROOT_W-1:0] root;
	} root_t;

endpackage

>>> src/primary_ray_direction.sv
// ----------------------------------------------------------------------------
// Primary ray direction
// Pinhole camera primary ray generator: pixel index in, unit direction out.
// ----------------------------------------------------------------------------
// Usage:
// Camera set-up is written through the cfg channel (cfg_valid/cfg_ready,
// cfg_index selects the register, cfg_data carries it); cfg_ready is always
// high. Write it only while no pixel is in flight.
// A pixel beat is taken on an edge with start high and busy low. busy is high
// only in the first cycle after reset; after that one pixel can be taken on
// every edge.
// Each result is on result for one cycle with done high, and results come out
// in order. The longest parts of the pipeline are the 31-stage square root and
// the one-bit-per-stage divider; throughput is one pixel per cycle.
// Reset clears all valid bits and loads the register reset values. The
// receiver cannot hold results off, so nothing stalls.
// ----------------------------------------------------------------------------
module primary_ray_direction import prd_pkg::*; #(
	parameter int unsigned MAX_IMAGE_SIZE = MAX_IMAGE_SIZE_DEF,
	parameter int unsigned DIR_FRAC_BITS  = DIR_FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  pixel_t               pixel,
	output logic                 done,
	output dir_t                 result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [VEC_W-1:0]     cfg_data
);

	cam_cfg_t cfg_q;
	logic     busy_q;
	logic     accept;
	logic     off_vld, prj_vld, sum_vld, root_vld;
	off_t     off;
	proj_t    prj;
	nsum_t    nsum;
	root_t    rt;

	assign cfg_ready = 1'b1;
	assign busy      = busy_q;
	assign accept    = start & ~busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{gaze: '0, up: '0, right: '0, near_dist: DIST_W'(65536),
				near_left: '0, near_top: '0, pix_w: '0, pix_h: '0};
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_GAZE:      cfg_q.gaze      <= cfg_data;
				REG_UP:        cfg_q.up        <= cfg_data;
				REG_RIGHT:     cfg_q.right     <= cfg_data;
				REG_NEAR_DIST: cfg_q.near_dist <= cfg_data[DIST_W-1:0];
				REG_NEAR_LEFT: cfg_q.near_left <= cfg_data[EDGE_W-1:0];
				REG_NEAR_TOP:  cfg_q.near_top  <= cfg_data[EDGE_W-1:0];
				REG_PIX_W:     cfg_q.pix_w     <= cfg_data[DIST_W-1:0];
				REG_PIX_H:     cfg_q.pix_h     <= cfg_data[DIST_W-1:0];
				default: begin
				end
			endcase
		end
	end

	prd_offset #(.MAX_IMAGE_SIZE(MAX_IMAGE_SIZE)) u_offset (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.pixel     (pixel),
		.cfg       (cfg_q),
		.out_valid (off_vld),
		.off       (off)
	);

	prd_project u_project (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (off_vld),
		.off       (off),
		.cfg       (cfg_q),
		.out_valid (prj_vld),
		.prj       (prj)
	);

	prd_normalize u_normalize (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (prj_vld),
		.prj       (prj),
		.out_valid (sum_vld),
		.nsum      (nsum)
	);

	prd_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sum_vld),
		.nsum      (nsum),
		.out_valid (root_vld),
		.rt        (rt)
	);

	prd_divide #(.DIR_FRAC_BITS(DIR_FRAC_BITS)) u_divide (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (root_vld),
		.rt        (rt),
		.out_valid (done),
		.dir       (result)
	);

endmodule

>>> src/prd_offset.sv
// ----------------------------------------------------------------------------
// Image plane offsets
// Clamps the pixel indices and forms the horizontal and vertical plane offsets
// in units of 2^-17 over three register stages.
// ----------------------------------------------------------------------------
module prd_offset import prd_pkg::*; #(
	parameter int unsigned MAX_IMAGE_SIZE = MAX_IMAGE_SIZE_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  pixel_t   pixel,
	input  cam_cfg_t cfg,
	output logic     out_valid,
	output off_t     off
);

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_IMAGE_SIZE - 1);

	logic [ROW_W-1:0]  row_c, col_c;
	logic              vld_s1, vld_s2, vld_s3;
	logic [ROW_W-1:0]  row_s1, col_s1;
	logic [PIXP_W-1:0] px_s2, py_s2;
	off_t              off_s3;

	always_comb begin
		row_c = ({(IDX_W-ROW_W)'(0), pixel.pixel_row} > IDX_LAST) ?
			IDX_LAST[ROW_W-1:0] : pixel.pixel_row;
		col_c = ({(IDX_W-ROW_W)'(0), pixel.pixel_column} > IDX_LAST) ?
			IDX_LAST[ROW_W-1:0] : pixel.pixel_column;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// The odd factors 2*index+1 put the sample at the pixel center.
	always_ff @(posedge clk) begin
		row_s1   <= row_c;
		col_s1   <= col_c;
		px_s2    <= PIXP_W'({col_s1, 1'b1}) * PIXP_W'(cfg.pix_w);
		py_s2    <= PIXP_W'({row_s1, 1'b1}) * PIXP_W'(cfg.pix_h);
		off_s3.h <= {{(H_W-EDGE_W-1){cfg.near_left[EDGE_W-1]}}, cfg.near_left, 1'b0}
			+ {2'b00, px_s2};
		off_s3.v <= {{(H_W-EDGE_W-1){cfg.near_top[EDGE_W-1]}}, cfg.near_top, 1'b0}
			- {2'b00, py_s2};
	end

	assign out_valid = vld_s3;
	assign off       = off_s3;

endmodule

>>> src/prd_project.sv
// ----------------------------------------------------------------------------
// Basis projection
// Multiplies the camera basis by the plane offsets, sums each component and
// splits it into sign and magnitude, one register stage per step.
// ----------------------------------------------------------------------------
module prd_project import prd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  off_t     off,
	input  cam_cfg_t cfg,
	output logic     out_valid,
	output proj_t    prj
);

	function automatic logic signed [COMP_W-1:0] comp(input logic [VEC_W-1:0] vec,
			input int unsigned k);
		return vec[COMP_W*k +: COMP_W];
	endfunction

	logic signed [DIST_W+1:0] dist2;
	logic                     vld_s1, vld_s2, vld_s3;
	logic signed [PROD_W-1:0] gd_s1 [3];
	logic signed [PROD_W-1:0] rh_s1 [3];
	logic signed [PROD_W-1:0] uv_s1 [3];
	logic signed [PROD_W-1:0] c_s2  [3];
	proj_t                    prj_s3;

	assign dist2 = {1'b0, cfg.near_dist, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			gd_s1[k] <= comp(cfg.gaze, k) * dist2;
			rh_s1[k] <= comp(cfg.right, k) * off.h;
			uv_s1[k] <= comp(cfg.up, k) * off.v;
			c_s2[k]  <= gd_s1[k] + rh_s1[k] + uv_s1[k];
			prj_s3.neg[k] <= c_s2[k][PROD_W-1];
			prj_s3.mag[k] <= c_s2[k][PROD_W-1] ? PROD_W'(-c_s2[k]) : PROD_W'(c_s2[k]);
		end
	end

	assign out_valid = vld_s3;
	assign prj       = prj_s3;

endmodule

>>> src/prd_normalize.sv
// ----------------------------------------------------------------------------
// Magnitude normalization
// Shifts the three magnitudes by one common amount so the largest one has its
// leading one at the top, then forms the sum of squares.
// ----------------------------------------------------------------------------
module prd_normalize import prd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  proj_t prj,
	output logic  out_valid,
	output nsum_t nsum
);

	localparam int unsigned SH_STAGES = 3;

	// The OR of all magnitudes has its leading one where the largest one has.
	function automatic logic [2:0][PROD_W-1:0] norm_step(
			input logic [2:0][PROD_W-1:0] m, input int unsigned s);
		logic [PROD_W-1:0]      any;
		logic [2:0][PROD_W-1:0] r;
		any = m[0] | m[1] | m[2];
		r   = m;
		if ((any >> (PROD_W - s)) == '0) begin
			for (int k = 0; k < 3; k++)
				r[k] = m[k] << s;
		end
		return r;
	endfunction

	logic                   vld_s [SH_STAGES+1];
	proj_t                  sh_s  [SH_STAGES+1];
	logic                   vld_s4, vld_s5;
	nrm_t                   nrm_s4, nrm_s5;
	logic [2:0][SQ_W-1:0]   sq_s4;
	logic [SUM_W-1:0]       sum_s5;
	nrm_t                   nrm_c;

	always_comb begin
		vld_s[0] = in_valid;
		sh_s[0]  = prj;
	end

	for (genvar j = 0; j < SH_STAGES; j++) begin : g_shift
		logic [2:0][PROD_W-1:0] m_c;

		always_comb begin
			m_c = norm_step(sh_s[j].mag, 32'd32 >> (2*j));
			m_c = norm_step(m_c, 32'd16 >> (2*j));
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			sh_s[j+1].neg <= sh_s[j].neg;
			sh_s[j+1].mag <= m_c;
		end
	end

	always_comb begin
		nrm_c.neg = sh_s[SH_STAGES].neg;
		for (int k = 0; k < 3; k++)
			nrm_c.mag[k] = sh_s[SH_STAGES].mag[k][PROD_W-1 -: MAG_W];
		nrm_c.zero = (nrm_c.mag == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s4 <= vld_s[SH_STAGES];
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		nrm_s4 <= nrm_c;
		for (int k = 0; k < 3; k++)
			sq_s4[k] <= SQ_W'(nrm_c.mag[k]) * SQ_W'(nrm_c.mag[k]);
		nrm_s5 <= nrm_s4;
		sum_s5 <= SUM_W'(sq_s4[0]) + SUM_W'(sq_s4[1]) + SUM_W'(sq_s4[2]);
	end

	assign out_valid = vld_s5;
	assign nsum.n    = nrm_s5;
	assign nsum.sum  = sum_s5;

endmodule

>>> src/prd_isqrt.sv
// ----------------------------------------------------------------------------
// Integer square root
// Bit-by-bit square root of the sum of squares, one result bit per register
// stage, carrying the remainder S - root^2 along.
// ----------------------------------------------------------------------------
module prd_isqrt import prd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  nsum_t nsum,
	output logic  out_valid,
	output root_t rt
);

	typedef struct packed {
		nrm_t              n;
		logic [ROOT_W-1:0] root;
		logic [SUM_W-1:0]  rem;
	} sqs_t;

	logic vld_s [ROOT_W+1];
	sqs_t st_s  [ROOT_W+1];

	always_comb begin
		vld_s[0]     = in_valid;
		st_s[0].n    = nsum.n;
		st_s[0].root = '0;
		st_s[0].rem  = nsum.sum;
	end

	for (genvar k = 0; k < ROOT_W; k++) begin : g_step
		localparam int unsigned B = ROOT_W - 1 - k;

		logic [TEST_W-1:0] trial;
		logic              take;

		// (root + 2^B)^2 - root^2 = root*2^(B+1) + 2^(2B)
		always_comb begin
			trial = (TEST_W'(st_s[k].root) << (B + 1)) | (TEST_W'(1) << (2 * B));
			take  = trial <= TEST_W'(st_s[k].rem);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			st_s[k+1].n    <= st_s[k].n;
			st_s[k+1].root <= take ? (st_s[k].root | (ROOT_W'(1) << B)) : st_s[k].root;
			st_s[k+1].rem  <= take ? (st_s[k].rem - trial[SUM_W-1:0]) : st_s[k].rem;
		end
	end

	assign out_valid = vld_s[ROOT_W];
	assign rt.n      = st_s[ROOT_W].n;
	assign rt.root   = st_s[ROOT_W].root;

endmodule

>>> src/prd_divide.sv
// ----------------------------------------------------------------------------
// Component division
// Restoring division of each magnitude by the root with rounding half up,
// one quotient bit per register stage, then sign, saturation and output.
// ----------------------------------------------------------------------------
module prd_divide import prd_pkg::*; #(
	parameter int unsigned DIR_FRAC_BITS = DIR_FRAC_BITS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  root_t rt,
	output logic  out_valid,
	output dir_t  dir
);

	localparam int unsigned QB    = DIR_FRAC_BITS + 1;
	localparam int unsigned NUM_W = MAG_W + DIR_FRAC_BITS + 1;
	localparam logic [QB-1:0] QMAX = QB'(1) << DIR_FRAC_BITS;

	typedef struct packed {
		logic                  zero;
		logic [2:0]            neg;
		logic [ROOT_W-1:0]     root;
		logic [2:0][NUM_W-1:0] rem;
		logic [2:0][QB-1:0]    q;
	} dvs_t;

	logic vld_s [QB+1];
	dvs_t st_s  [QB+1];
	logic done_q;
	dir_t dir_q;
	logic [2:0][OUT_W-1:0] res_c;

	always_comb begin
		vld_s[0]     = in_valid;
		st_s[0].zero = rt.n.zero;
		st_s[0].neg  = rt.n.neg;
		st_s[0].root = rt.root;
		st_s[0].q    = '0;
		for (int k = 0; k < 3; k++)
			st_s[0].rem[k] = {1'b0, rt.n.mag[k], DIR_FRAC_BITS'(0)}
				+ NUM_W'(rt.root[ROOT_W-1:1]);
	end

	for (genvar j = 0; j < QB; j++) begin : g_step
		localparam int unsigned B = QB - 1 - j;

		logic [NUM_W-1:0] den;
		logic [2:0]       take;

		always_comb begin
			den = NUM_W'(st_s[j].root) << B;
			for (int k = 0; k < 3; k++)
				take[k] = st_s[j].rem[k] >= den;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			st_s[j+1].zero <= st_s[j].zero;
			st_s[j+1].neg  <= st_s[j].neg;
			st_s[j+1].root <= st_s[j].root;
			for (int k = 0; k < 3; k++) begin
				st_s[j+1].rem[k] <= take[k] ? (st_s[j].rem[k] - den) : st_s[j].rem[k];
				st_s[j+1].q[k]   <= take[k] ? (st_s[j].q[k] | (QB'(1) << B)) : st_s[j].q[k];
			end
		end
	end

	always_comb begin
		logic [31:0] o;
		logic [31:0] sat;
		for (int k = 0; k < 3; k++) begin
			o = 32'(st_s[QB].q[k]);
			if (st_s[QB].neg[k]) begin
				sat      = (o > OUT_NEG_MAX) ? OUT_NEG_MAX : o;
				res_c[k] = OUT_W'(32'd0 - sat);
			end else begin
				sat      = (o > OUT_POS_MAX) ? OUT_POS_MAX : o;
				res_c[k] = sat[OUT_W-1:0];
			end
			if (st_s[QB].zero)
				res_c[k] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		dir_q.dir_x <= res_c[0];
		dir_q.dir_y <= res_c[1];
		dir_q.dir_z <= res_c[2];
	end

	assign out_valid = done_q;
	assign dir       = dir_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(in_valid, QB + 1))
		else $error("result beat without a matching item");

	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !rt.n.zero |-> rt.root[ROOT_W-1:ROOT_W-2] != 2'b00)
		else $error("root below the normalized range");

	a_zero_mag: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && rt.n.zero |-> rt.n.mag == '0)
		else $error("zero flag set with nonzero magnitude");

	a_quot_max: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[QB] && !st_s[QB].zero |->
			st_s[QB].q[0] <= QMAX && st_s[QB].q[1] <= QMAX && st_s[QB].q[2] <= QMAX)
		else $error("quotient above unit length");

endmodule
